[hdl/sha_pkg.sv]
// Shared types and constants for the SHA-256 engine.
// Round constants, initial hash values and the controller state type.
package sha_pkg;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_PAD,
    ST_LEN,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_e;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [3:0] LEN_WORD = 4'd14;  // first word of the length field

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

[hdl/sha_ram.sv]
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module sha_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[hdl/sha256_hash_engine.sv]
// SHA-256 engine: byte stream in, eight digest words out. A byte is taken each cycle while
// filling; a block's 64th byte holds the input off for 64 rounds at one a cycle and an add.
// End marker: the rest of the block is filled at one word a cycle, then it is compressed
// (twice when the marker lands at byte 56 or later); the digest words then follow at one
// word a cycle while m_axis_tready is high.
// Reset (async, low) loads the initial hash and clears the bit count; block RAM stays undefined.
module sha256_hash_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, zero pad
  output logic        m_axis_tlast    // last_word
);
  import sha_pkg::*;

  state_e state_q, state_d;
  logic [63:0] bits_q, bits_d;
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] buf_q, buf_d;       // word being assembled from bytes
  logic [5:0]  rnd_q, rnd_d;
  logic [3:0]  pw_q, pw_d;          // padding word index
  logic        fin_q, fin_d;        // compression is the final one
  logic [2:0]  oi_q, oi_d;
  logic        ovalid_q, ovalid_d;

  // schedule RAM: 16 words, circular window of the message schedule
  logic        we;
  logic [3:0]  waddr, raddr;
  logic [31:0] wdata, rdata;
  sha_ram #(.Width(32), .Depth(16)) u_w (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );

  // Schedule: w[t] for t>=16 needs w[t-16], w[t-15], w[t-7], w[t-2]; only one RAM read per
  // cycle, so a 16-entry shift window in flops holds the live words during the rounds.
  logic [31:0] win_q [16];
  logic [31:0] s0, s1, wnew, wt, sum1, ch, sum0, maj, t1;
  logic [5:0]  pos;
  logic        acc, byte_in;

  assign pos     = bits_q[8:3];
  assign s_axis_tready = (state_q == ST_FILL) && !ovalid_q;
  assign acc     = s_axis_tvalid && s_axis_tready;
  assign byte_in = acc && !s_axis_tuser;

  always_comb begin
    s0   = rotr(win_q[1], 7) ^ rotr(win_q[1], 18) ^ (win_q[1] >> 3);
    s1   = rotr(win_q[14], 17) ^ rotr(win_q[14], 19) ^ (win_q[14] >> 10);
    wnew = s1 + win_q[9] + s0 + win_q[0];
    wt   = (rnd_q < 6'd16) ? rdata : wnew;
    sum1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1   = v_q[7] + sum1 + ch + ROUND_K[rnd_q] + wt;
    sum0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_FILL: begin
        if (byte_in && pos == 6'd63) state_d = ST_ROUND;
        else if (acc && s_axis_tuser) begin
          // pad word closes the block, lands just before the length, or zeros follow
          if (pos[5:2] == 4'd15) state_d = ST_ROUND;
          else if (pos[5:2] == LEN_WORD - 4'd1) state_d = ST_LEN;
          else state_d = ST_PAD;
        end
      end
      ST_PAD: begin
        if (pw_q == 4'd15) state_d = ST_ROUND;
        else if (pw_q == LEN_WORD - 4'd1 && fin_q) state_d = ST_LEN;
      end
      ST_LEN:   if (pw_q == 4'd15) state_d = ST_ROUND;
      ST_ROUND: if (rnd_q == 6'd63) state_d = ST_ADD;
      ST_ADD:   state_d = fin_q ? ST_EMIT : (pw_q == 4'd0 ? ST_FILL : ST_PAD);
      ST_EMIT:  if (ovalid_q && m_axis_tready && oi_q == 3'd7) state_d = ST_FILL;
      default:  state_d = ST_FILL;
    endcase
  end

  // datapath control
  always_comb begin
    bits_d = bits_q; buf_d = buf_q; rnd_d = rnd_q; pw_d = pw_q; fin_d = fin_q;
    oi_d = oi_q; ovalid_d = ovalid_q;
    we = 1'b0; waddr = pos[5:2]; wdata = buf_q; raddr = 4'd0;
    case (state_q)
      ST_FILL: begin
        if (byte_in) begin
          bits_d = bits_q + 64'd8;
          buf_d  = {buf_q[23:0], s_axis_tdata};
          if (pos[1:0] == 2'd3) begin
            we = 1'b1; wdata = {buf_q[23:0], s_axis_tdata};
          end
          raddr = 4'd0;
          rnd_d = 6'd0;
          fin_d = 1'b0;
          pw_d  = 4'd0;
        end else if (acc) begin
          // close the partial word with the pad byte
          case (pos[1:0])
            2'd0:    wdata = {PAD_BYTE, 24'd0};
            2'd1:    wdata = {buf_q[7:0], PAD_BYTE, 16'd0};
            2'd2:    wdata = {buf_q[15:0], PAD_BYTE, 8'd0};
            default: wdata = {buf_q[23:0], PAD_BYTE};
          endcase
          we    = 1'b1;
          // a nonzero index after a non-final compression marks the overflow block
          pw_d  = (pos[5:2] == 4'd15) ? 4'd15 : pos[5:2] + 4'd1;
          fin_d = (pos < 6'd56);
          rnd_d = 6'd0;
          if (pos[5:2] == 4'd15) raddr = 4'd0;
        end
      end
      ST_PAD: begin
        we = 1'b1; waddr = pw_q; wdata = 32'd0;
        pw_d = (pw_q == 4'd15) ? pw_q : pw_q + 4'd1;
        if (pw_q == LEN_WORD - 4'd1 && !fin_q && pw_q != 4'd15) fin_d = 1'b0;
        raddr = 4'd0; rnd_d = 6'd0;
      end
      ST_LEN: begin
        we = 1'b1; waddr = pw_q;
        wdata = (pw_q == LEN_WORD) ? bits_q[63:32] : bits_q[31:0];
        pw_d = pw_q + 4'd1; raddr = 4'd0; rnd_d = 6'd0;
      end
      ST_ROUND: begin
        rnd_d = rnd_q + 6'd1;
        raddr = rnd_q[3:0] + 4'd1;
      end
      ST_ADD: begin
        // a non-final compression here is the overflow block of padding
        if (!fin_q && pw_q != 4'd0) begin
          fin_d = 1'b1; pw_d = 4'd0;
        end
        if (fin_q) begin
          ovalid_d = 1'b1; oi_d = 3'd0;
        end
      end
      ST_EMIT: begin
        if (ovalid_q && m_axis_tready) begin
          oi_d = oi_q + 3'd1;
          if (oi_q == 3'd7) begin
            ovalid_d = 1'b0; bits_d = 64'd0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL; bits_q <= 64'd0; rnd_q <= 6'd0; pw_q <= 4'd0;
      fin_q <= 1'b0; oi_q <= 3'd0; ovalid_q <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= INIT_H[i];
    end else begin
      state_q <= state_d; bits_q <= bits_d; rnd_q <= rnd_d; pw_q <= pw_d;
      fin_q <= fin_d; oi_q <= oi_d; ovalid_q <= ovalid_d;
      if (state_q == ST_ADD) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end else if (state_q == ST_EMIT && ovalid_q && m_axis_tready && oi_q == 3'd7) begin
        for (int i = 0; i < 8; i++) h_q[i] <= INIT_H[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    if (state_q == ST_ROUND) begin
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4]; v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0]; v_q[0] <= t1 + sum0 + maj;
      for (int i = 0; i < 15; i++) win_q[i] <= win_q[i + 1];
      win_q[15] <= wt;
    end else begin
      for (int i = 0; i < 8; i++) v_q[i] <= (state_q == ST_ADD) ? h_q[i] + v_q[i] : h_q[i];
    end
  end

  // pad-phase fix: when the marker lands past byte 55, the zeros run to word 15 and a second
  // block follows; fin_q stays low until the overflow block is done (handled in ST_ADD).

  logic [31:0] hout;
  always_comb begin
    hout = h_q[oi_q];
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {5'd0, oi_q, hout};
  assign m_axis_tlast  = (oi_q == 3'd7);

  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_FILL) |-> !s_axis_tready) else $error("input taken while busy");
  a_round_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND && rnd_q != 6'd63) |=> (state_q == ST_ROUND))
    else $error("round loop broken");
  a_out_only_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (state_q == ST_EMIT)) else $error("word outside emit");
  a_bits_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (bits_q == 64'd0))
    else $error("bit count not cleared");
endmodule

[verif/sha256_hash_engine_test.sv]
// Self-checking testbench for sha256_hash_engine: a byte stream with end markers in,
// digest words out, checked against a SHA-256 predictor kept here. Needs hdl/sha_pkg.sv.
`timescale 1ns / 1ps

module sha256_hash_engine_test;
  import sha_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } byte_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_item_t;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;
  localparam int   STALL_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  sha256_hash_engine u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  initial forever #1 clk_i = ~clk_i;

  byte_item_t   pending_bytes[$];
  digest_item_t expected_words[$];
  int           mismatches = 0;
  int           idle_cycles = 0;
  bit           calm = 1'b0;  // no idling on either side while set

  // predictor state
  logic [31:0] hv [8];
  logic [7:0]  blk [64];
  logic [63:0] bit_count;

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_blk();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    v = hv;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hv[i] += v[i];
  endtask

  task automatic hash_restart();
    hv = INIT_H;
    bit_count = '0;
  endtask

  task automatic predict_digest(byte_item_t it);
    int pos;
    pos = int'(bit_count[8:3]);
    if (it.kind == KIND_BYTE) begin
      blk[pos] = it.data_byte;
      bit_count += 64'd8;
      if (pos == 63) compress_blk();
      return;
    end
    blk[pos] = PAD_BYTE;
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin
        blk[pos] = 8'h00;
        pos++;
      end
      compress_blk();
      pos = 0;
    end
    while (pos < 56) begin
      blk[pos] = 8'h00;
      pos++;
    end
    for (int i = 0; i < 8; i++) blk[56+i] = bit_count[63-8*i -: 8];
    compress_blk();
    for (int i = 0; i < 8; i++)
      expected_words.push_back('{hv[i], 3'(i), i == 7});
    hash_restart();
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  task automatic add_message(int len);
    for (int i = 0; i < len; i++)
      pending_bytes.push_back('{KIND_BYTE, 8'($urandom_range(0, 255))});
    pending_bytes.push_back('{KIND_END, 8'($urandom_range(0, 255))});
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_digest('{s_axis_tuser, s_axis_tdata});
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_bytes.size() > 0 && (calm || $urandom_range(0, 99) >= 30)) begin
          byte_item_t nx;
          nx = pending_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= nx.kind;
          s_axis_tdata  <= nx.data_byte;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 30);
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", m_axis_tdata[31:0], '0);
        end else begin
          digest_item_t ex;
          ex = expected_words.pop_front();
          if (m_axis_tdata[31:0] !== ex.digest_word)
            report_mismatch("digest_word", m_axis_tdata[31:0], ex.digest_word);
          if (m_axis_tdata[34:32] !== ex.word_index)
            report_mismatch("word_index", {29'd0, m_axis_tdata[34:32]},
                            {29'd0, ex.word_index});
          if (m_axis_tlast !== ex.last_word)
            report_mismatch("last_word", {31'd0, m_axis_tlast}, {31'd0, ex.last_word});
        end
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("sha256_hash_engine regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int budget;
    hash_restart();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: empty, short, the 55/56/63/64-byte padding edges, all-ones and zero bytes
    add_message(0);
    pending_bytes.push_back('{KIND_BYTE, 8'h00});
    pending_bytes.push_back('{KIND_BYTE, 8'hff});
    pending_bytes.push_back('{KIND_END, 8'hff});
    pending_bytes.push_back('{KIND_END, 8'h00});
    add_message(3);
    wait (pending_bytes.size() == 0);
    // long stretch with both sides always ready
    calm = 1'b1;
    add_message(55);
    add_message(56);
    wait (pending_bytes.size() == 0);
    calm = 1'b0;
    add_message(63);
    add_message(64);
    wait (pending_bytes.size() == 0);
    // random: short messages to round off the item count
    budget = 30;
    while (budget > 0) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 20);
      if (len > budget - 1) len = budget - 1;
      add_message(len);
      budget -= len + 1;
      wait (pending_bytes.size() < 8);
    end
    wait (pending_bytes.size() == 0);
    @(posedge clk_i);
    wait (!s_axis_tvalid && expected_words.size() == 0);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0)
      $display("sha256_hash_engine regression: pass");
    else
      $display("sha256_hash_engine regression: fail");
    $finish;
  end

endmodule
